### rtl/core/yfdtd_pkg.sv
`timescale 1ns / 1ps

package yfdtd_pkg;

    // grid geometry
    localparam int GRID_SIZE = 32;
    localparam int IW        = $clog2(GRID_SIZE);
    localparam int CELLS     = GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam int AW        = $clog2(CELLS);

    // datapath widths
    localparam int DW            = 32;
    localparam int CW            = 17;
    localparam int SUM_W         = 50;
    localparam int RND_W         = 48;
    localparam int COURANT_RESET = 32768;

    // action codes
    localparam logic [2:0] ACT_WR_E = 3'd0;
    localparam logic [2:0] ACT_WR_H = 3'd1;
    localparam logic [2:0] ACT_WR_P = 3'd2;
    localparam logic [2:0] ACT_RD_E = 3'd3;
    localparam logic [2:0] ACT_RD_H = 3'd4;
    localparam logic [2:0] ACT_STEP = 3'd5;

    // component codes
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef logic [AW-1:0] t_addr;
    typedef logic [IW-1:0] t_idx;

    typedef struct packed {
        logic  clr_we;
        t_addr clr_addr;
        logic  acc_go;
        logic  step_start;
        logic  iss_a;
        logic  iss_b;
        logic  sweep_e;
        t_idx  ci;
        t_idx  cj;
        t_idx  ck;
        logic  ld_imm;
        logic  ld_read;
        logic  ld_step;
    } t_cmd;

    typedef struct packed {
        logic pipe_busy;
    } t_sts;

    function automatic t_addr cell_addr(input t_addr i, input t_addr j, input t_addr k);
        return t_addr'(i * t_addr'(GRID_SIZE * GRID_SIZE) + j * t_addr'(GRID_SIZE) + k);
    endfunction

    // neighbor stride: first read along one axis, second along the other
    function automatic t_addr off_stride(input int comp, input logic second);
        t_addr s;
        s = t_addr'(1);
        case (comp)
            0: s = second ? t_addr'(GRID_SIZE) : t_addr'(1);
            1: s = second ? t_addr'(GRID_SIZE * GRID_SIZE) : t_addr'(1);
            default: s = second ? t_addr'(GRID_SIZE * GRID_SIZE) : t_addr'(GRID_SIZE);
        endcase
        return s;
    endfunction

    // round to nearest of x / 2^16, ties up
    function automatic logic signed [RND_W-1:0] rnd16(input logic signed [63:0] x);
        logic signed [63:0] t;
        t = x + 64'sd32768;
        return t[63:16];
    endfunction

    function automatic logic sum_ovf(input logic signed [SUM_W-1:0] v);
        return !((&v[SUM_W-1:DW-1]) || (~|v[SUM_W-1:DW-1]));
    endfunction

    function automatic logic signed [DW-1:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [DW-1:0] r;
        r = v[DW-1:0];
        if (sum_ovf(v)) begin
            r = v[SUM_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

### rtl/core/yfdtd_if.sv
`timescale 1ns / 1ps

interface yfdtd_req_if;
    logic                              valid;
    logic                              ready;
    logic [2:0]                        action;
    logic [1:0]                        component;
    logic [4:0]                        cell_x;
    logic [4:0]                        cell_y;
    logic [4:0]                        cell_z;
    logic signed [yfdtd_pkg::DW-1:0]   write_value;
    logic signed [yfdtd_pkg::DW-1:0]   source_amplitude;

    modport source (output valid, action, component, cell_x, cell_y, cell_z,
                    write_value, source_amplitude, input ready);
    modport sink   (input valid, action, component, cell_x, cell_y, cell_z,
                    write_value, source_amplitude, output ready);
endinterface

interface yfdtd_res_if;
    logic                              valid;
    logic                              ready;
    logic signed [yfdtd_pkg::DW-1:0]   read_value;
    logic                              saturated;
    logic                              done_res;

    modport source (output valid, read_value, saturated, done_res, input ready);
    modport sink   (input valid, read_value, saturated, done_res, output ready);
endinterface

interface yfdtd_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [yfdtd_pkg::CW-1:0]     data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### rtl/core/yfdtd_ctrl.sv
`timescale 1ns / 1ps

module yfdtd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic [2:0]        i_action,
    output logic              o_req_ready,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    input  yfdtd_pkg::t_sts   i_sts,
    output yfdtd_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_READ    = 3'd2;
    localparam logic [2:0] ST_E_RUN   = 3'd3;
    localparam logic [2:0] ST_E_DRAIN = 3'd4;
    localparam logic [2:0] ST_H_RUN   = 3'd5;
    localparam logic [2:0] ST_H_DRAIN = 3'd6;

    localparam yfdtd_pkg::t_idx LAST = yfdtd_pkg::t_idx'(yfdtd_pkg::GRID_SIZE - 2);

    logic [2:0]         r_state, n_state;
    yfdtd_pkg::t_addr   r_clr, n_clr;
    yfdtd_pkg::t_idx    r_ci, n_ci, r_cj, n_cj, r_ck, n_ck;
    logic               r_ph, n_ph;
    logic               r_ov, n_ov;
    logic               w_ready, w_acc, w_last;

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_ci    = r_ci;
        n_cj    = r_cj;
        n_ck    = r_ck;
        n_ph    = r_ph;
        n_ov    = r_ov;
        o_cmd   = '0;
        o_cmd.clr_addr = r_clr;
        o_cmd.ci       = r_ci;
        o_cmd.cj       = r_cj;
        o_cmd.ck       = r_ck;
        o_cmd.sweep_e  = (r_state == ST_E_RUN) || (r_state == ST_E_DRAIN);
        w_ready = (r_state == ST_IDLE) && (!r_ov || i_res_ready);
        w_acc   = i_req_valid && w_ready;
        w_last  = (r_ci == LAST) && (r_cj == LAST) && (r_ck == LAST);
        if (r_ov && i_res_ready) begin
            n_ov = 1'b0;
        end
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                n_clr = r_clr + yfdtd_pkg::t_addr'(1);
                if (r_clr == yfdtd_pkg::t_addr'(yfdtd_pkg::CELLS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_acc) begin
                    o_cmd.acc_go = 1'b1;
                    if (i_action == yfdtd_pkg::ACT_RD_E || i_action == yfdtd_pkg::ACT_RD_H) begin
                        n_state = ST_READ;
                    end else if (i_action == yfdtd_pkg::ACT_STEP) begin
                        o_cmd.step_start = 1'b1;
                        n_state = ST_E_RUN;
                        n_ph = 1'b0;
                        n_ci = '0;
                        n_cj = '0;
                        n_ck = '0;
                    end else begin
                        o_cmd.ld_imm = 1'b1;
                        n_ov = 1'b1;
                    end
                end
            end
            ST_READ: begin
                o_cmd.ld_read = 1'b1;
                n_ov = 1'b1;
                n_state = ST_IDLE;
            end
            ST_E_RUN, ST_H_RUN: begin
                n_ph = !r_ph;
                if (!r_ph) begin
                    o_cmd.iss_a = 1'b1;
                end else begin
                    o_cmd.iss_b = 1'b1;
                    if (r_ck == LAST) begin
                        n_ck = '0;
                        if (r_cj == LAST) begin
                            n_cj = '0;
                            if (r_ci == LAST) begin
                                n_ci = '0;
                            end else begin
                                n_ci = r_ci + yfdtd_pkg::t_idx'(1);
                            end
                        end else begin
                            n_cj = r_cj + yfdtd_pkg::t_idx'(1);
                        end
                    end else begin
                        n_ck = r_ck + yfdtd_pkg::t_idx'(1);
                    end
                    if (w_last) begin
                        n_state = (r_state == ST_E_RUN) ? ST_E_DRAIN : ST_H_DRAIN;
                    end
                end
            end
            ST_E_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = ST_H_RUN;
                end
            end
            ST_H_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    o_cmd.ld_step = 1'b1;
                    n_ov = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_ci    <= '0;
            r_cj    <= '0;
            r_ck    <= '0;
            r_ph    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ci    <= n_ci;
            r_cj    <= n_cj;
            r_ck    <= n_ck;
            r_ph    <= n_ph;
            r_ov    <= n_ov;
        end
    end

    assign o_req_ready = w_ready;
    assign o_res_valid = r_ov;

endmodule

### rtl/core/yfdtd_dp.sv
`timescale 1ns / 1ps

module yfdtd_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  yfdtd_pkg::t_cmd                   i_cmd,
    output yfdtd_pkg::t_sts                   o_sts,
    input  logic [2:0]                        i_action,
    input  logic [1:0]                        i_component,
    input  logic [4:0]                        i_cell_x,
    input  logic [4:0]                        i_cell_y,
    input  logic [4:0]                        i_cell_z,
    input  logic signed [yfdtd_pkg::DW-1:0]   i_write_value,
    input  logic signed [yfdtd_pkg::DW-1:0]   i_source_amplitude,
    input  logic                              i_cfg_we,
    input  logic [yfdtd_pkg::CW-1:0]          i_cfg_data,
    output logic signed [yfdtd_pkg::DW-1:0]   o_read_value,
    output logic                              o_saturated,
    output logic                              o_done_res
);

    localparam int DW    = yfdtd_pkg::DW;
    localparam int SUM_W = yfdtd_pkg::SUM_W;
    localparam int RND_W = yfdtd_pkg::RND_W;

    logic [yfdtd_pkg::CW-1:0]   r_courant;
    logic signed [DW-1:0]       r_amp;

    yfdtd_pkg::t_addr w_center, w_acc_addr, w_rda_addr, w_wr_addr;
    logic w_in_grid, w_comp_ok;

    // memory ports, index 0..2 = E x/y/z, 3..5 = H x/y/z
    logic signed [DW-1:0] w_fa [6];
    logic signed [DW-1:0] w_fb [6];
    logic signed [DW-1:0] w_pa;
    logic signed [DW-1:0] w_swd [3];

    // pipeline valids and cell addresses
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    yfdtd_pkg::t_addr r_adr1, r_adr2, r_adr3, r_adr4, r_adr5;

    logic signed [DW-1:0]      r_oth_c [3];
    logic signed [DW-1:0]      r_oth_1 [3];
    logic signed [DW-1:0]      r_own1 [3];
    logic signed [DW-1:0]      r_own2 [3];
    logic signed [DW-1:0]      r_own3 [3];
    logic signed [DW-1:0]      r_prof1;
    logic signed [DW:0]        w_d1 [3];
    logic signed [DW:0]        w_d2 [3];
    logic signed [DW+1:0]      w_curl [3];
    logic signed [DW+1:0]      r_curl [3];
    logic signed [63:0]        r_sprod;
    logic signed [51:0]        r_prod [3];
    logic signed [RND_W-1:0]   r_srnd3, r_srnd4;
    logic signed [RND_W-1:0]   w_rnd [3];
    logic signed [SUM_W-1:0]   w_sum [3];
    logic signed [DW-1:0]      r_new [3];
    logic                      r_satf;
    logic signed [SUM_W-1:0]   w_z2;
    logic                      w_ovf2;
    logic                      r_acc_sat;

    logic       r_acc_ok, r_acc_h;
    logic [1:0] r_acc_comp;
    logic signed [DW-1:0] w_rd_sel;

    // addressing
    assign w_center = yfdtd_pkg::cell_addr(
        yfdtd_pkg::t_addr'(i_cmd.ci) + yfdtd_pkg::t_addr'(i_cmd.sweep_e),
        yfdtd_pkg::t_addr'(i_cmd.cj) + yfdtd_pkg::t_addr'(i_cmd.sweep_e),
        yfdtd_pkg::t_addr'(i_cmd.ck) + yfdtd_pkg::t_addr'(i_cmd.sweep_e));
    assign w_acc_addr = yfdtd_pkg::cell_addr(yfdtd_pkg::t_addr'(i_cell_x),
                                             yfdtd_pkg::t_addr'(i_cell_y),
                                             yfdtd_pkg::t_addr'(i_cell_z));
    assign w_in_grid  = (int'(i_cell_x) < yfdtd_pkg::GRID_SIZE)
                     && (int'(i_cell_y) < yfdtd_pkg::GRID_SIZE)
                     && (int'(i_cell_z) < yfdtd_pkg::GRID_SIZE);
    assign w_comp_ok  = (i_component == yfdtd_pkg::COMP_X)
                     || (i_component == yfdtd_pkg::COMP_Y)
                     || (i_component == yfdtd_pkg::COMP_Z);
    assign w_rda_addr = i_cmd.iss_a ? w_center : w_acc_addr;
    assign w_wr_addr  = i_cmd.clr_we ? i_cmd.clr_addr : (r_v5 ? r_adr5 : w_acc_addr);

    // field memories
    for (genvar m = 0; m < 6; m++) begin : g_fld
        localparam int Comp = m % 3;
        logic signed [DW-1:0] r_mem [yfdtd_pkg::CELLS];
        logic signed [DW-1:0] r_rda, r_rdb;
        yfdtd_pkg::t_addr     w_stride, w_rdb_addr;
        logic                 w_own, w_acc_we, w_we;
        logic signed [DW-1:0] w_wd;

        assign w_stride   = yfdtd_pkg::off_stride(Comp, i_cmd.iss_b);
        assign w_rdb_addr = i_cmd.sweep_e ? w_center - w_stride : w_center + w_stride;
        assign w_own      = (m < 3) ? i_cmd.sweep_e : !i_cmd.sweep_e;
        assign w_acc_we   = i_cmd.acc_go && w_in_grid
                         && (i_component == 2'(Comp))
                         && (((m < 3) && (i_action == yfdtd_pkg::ACT_WR_E))
                          || ((m >= 3) && (i_action == yfdtd_pkg::ACT_WR_H)));
        assign w_we = i_cmd.clr_we || (r_v5 && w_own) || w_acc_we;
        assign w_wd = i_cmd.clr_we ? '0 : (r_v5 ? w_swd[Comp] : i_write_value);

        always_ff @(posedge i_clk) begin
            if (w_we) begin
                r_mem[w_wr_addr] <= w_wd;
            end
            r_rda <= r_mem[w_rda_addr];
            r_rdb <= r_mem[w_rdb_addr];
        end

        assign w_fa[m] = r_rda;
        assign w_fb[m] = r_rdb;
    end

    // source profile memory
    logic signed [DW-1:0] r_pmem [yfdtd_pkg::CELLS];
    logic signed [DW-1:0] r_prda;
    logic                 w_pwe;

    assign w_pwe = i_cmd.clr_we
                || (i_cmd.acc_go && w_in_grid && (i_action == yfdtd_pkg::ACT_WR_P));

    always_ff @(posedge i_clk) begin
        if (w_pwe) begin
            r_pmem[w_wr_addr] <= i_cmd.clr_we ? '0 : i_write_value;
        end
        r_prda <= r_pmem[w_rda_addr];
    end
    assign w_pa = r_prda;

    // curl, scale, accumulate
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (i_cmd.sweep_e) begin
                w_d1[c] = (DW+1)'(r_oth_c[c]) - (DW+1)'(r_oth_1[c]);
                w_d2[c] = (DW+1)'(r_oth_c[c]) - (DW+1)'(w_fb[c+3]);
            end else begin
                w_d1[c] = (DW+1)'(r_oth_1[c]) - (DW+1)'(r_oth_c[c]);
                w_d2[c] = (DW+1)'(w_fb[c]) - (DW+1)'(r_oth_c[c]);
            end
        end
        w_curl[0] = (DW+2)'(w_d1[2]) - (DW+2)'(w_d1[1]);
        w_curl[1] = (DW+2)'(w_d1[0]) - (DW+2)'(w_d2[2]);
        w_curl[2] = (DW+2)'(w_d2[1]) - (DW+2)'(w_d2[0]);
        for (int c = 0; c < 3; c++) begin
            w_rnd[c] = yfdtd_pkg::rnd16(64'(r_prod[c]));
            w_sum[c] = i_cmd.sweep_e ? SUM_W'(r_own3[c]) + SUM_W'(w_rnd[c])
                                     : SUM_W'(r_own3[c]) - SUM_W'(w_rnd[c]);
        end
        w_z2   = SUM_W'(r_new[2]) + SUM_W'(r_srnd4);
        w_ovf2 = i_cmd.sweep_e && yfdtd_pkg::sum_ovf(w_z2);
        w_swd[0] = r_new[0];
        w_swd[1] = r_new[1];
        w_swd[2] = i_cmd.sweep_e ? yfdtd_pkg::sat32(w_z2) : r_new[2];
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_oth_c[c] <= i_cmd.sweep_e ? w_fa[c+3] : w_fa[c];
            r_oth_1[c] <= i_cmd.sweep_e ? w_fb[c+3] : w_fb[c];
            r_own1[c]  <= i_cmd.sweep_e ? w_fa[c] : w_fa[c+3];
            r_own2[c]  <= r_own1[c];
            r_own3[c]  <= r_own2[c];
            r_curl[c]  <= w_curl[c];
            r_prod[c]  <= r_curl[c] * $signed({1'b0, r_courant});
            r_new[c]   <= yfdtd_pkg::sat32(w_sum[c]);
        end
        r_prof1 <= w_pa;
        r_sprod <= r_amp * r_prof1;
        r_srnd3 <= yfdtd_pkg::rnd16(r_sprod);
        r_srnd4 <= r_srnd3;
        r_satf  <= yfdtd_pkg::sum_ovf(w_sum[0]) || yfdtd_pkg::sum_ovf(w_sum[1])
                || yfdtd_pkg::sum_ovf(w_sum[2]);
        r_adr1  <= w_center;
        r_adr2  <= r_adr1;
        r_adr3  <= r_adr2;
        r_adr4  <= r_adr3;
        r_adr5  <= r_adr4;
        if (i_cmd.step_start) begin
            r_amp <= i_source_amplitude;
        end
        if (i_cmd.acc_go) begin
            r_acc_ok   <= w_in_grid && w_comp_ok;
            r_acc_h    <= (i_action == yfdtd_pkg::ACT_RD_H);
            r_acc_comp <= i_component;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_v5      <= 1'b0;
            r_acc_sat <= 1'b0;
            r_courant <= yfdtd_pkg::CW'(yfdtd_pkg::COURANT_RESET);
        end else begin
            r_v1 <= i_cmd.iss_a;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            if (i_cmd.step_start) begin
                r_acc_sat <= 1'b0;
            end else if (r_v5) begin
                r_acc_sat <= r_acc_sat || r_satf || w_ovf2;
            end
            if (i_cfg_we) begin
                r_courant <= i_cfg_data;
            end
        end
    end

    assign o_sts.pipe_busy = r_v1 || r_v2 || r_v3 || r_v4 || r_v5;

    // result register
    always_comb begin
        case (r_acc_comp)
            yfdtd_pkg::COMP_X: w_rd_sel = r_acc_h ? w_fa[3] : w_fa[0];
            yfdtd_pkg::COMP_Y: w_rd_sel = r_acc_h ? w_fa[4] : w_fa[1];
            yfdtd_pkg::COMP_Z: w_rd_sel = r_acc_h ? w_fa[5] : w_fa[2];
            default:           w_rd_sel = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_imm) begin
            o_read_value <= '0;
            o_saturated  <= 1'b0;
            o_done_res   <= (i_action <= yfdtd_pkg::ACT_STEP);
        end else if (i_cmd.ld_read) begin
            o_read_value <= r_acc_ok ? w_rd_sel : '0;
            o_saturated  <= 1'b0;
            o_done_res   <= 1'b1;
        end else if (i_cmd.ld_step) begin
            o_read_value <= '0;
            o_saturated  <= r_acc_sat;
            o_done_res   <= 1'b1;
        end
    end

endmodule

### rtl/core/yee_fdtd_3d_step.sv
`timescale 1ns / 1ps

// 3-D Yee leapfrog field engine, Q16.16. Holds E and H (three components each) and a
// source profile on a cubic grid of yfdtd_pkg::GRID_SIZE cells per axis. After reset a
// clearing pass zeroes all memories, one cell per cycle, during which no request is
// taken. Writes and undefined actions answer in the cycle after acceptance; reads pass
// through a read state first. A step sweeps the E cells with indices 1 to GRID_SIZE-1
// and then the H cells with indices 0 to GRID_SIZE-2, issuing each cell over an A phase
// and a B phase because each neighbor field memory must be read at three addresses
// through its two read ports; each sweep is followed by a drain of the curl pipeline.
// The courant ratio is written through the configuration channel, which is always ready;
// the user must write it only while no request is in flight: the block does not enforce it.
module yee_fdtd_3d_step (
    input  logic         i_clk,
    input  logic         i_rst_n,
    yfdtd_req_if.sink    i_req,
    yfdtd_res_if.source  o_res,
    yfdtd_cfg_if.sink    i_cfg
);

    yfdtd_pkg::t_cmd w_cmd;
    yfdtd_pkg::t_sts w_sts;

    // config register lives in the datapath, writes always taken
    assign i_cfg.ready = 1'b1;

    // sequencer: clearing pass, request decode, sweep counters, result valid
    yfdtd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_action    (i_req.action),
        .o_req_ready (i_req.ready),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // memories, curl pipeline and result payload
    yfdtd_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_action           (i_req.action),
        .i_component        (i_req.component),
        .i_cell_x           (i_req.cell_x),
        .i_cell_y           (i_req.cell_y),
        .i_cell_z           (i_req.cell_z),
        .i_write_value      (i_req.write_value),
        .i_source_amplitude (i_req.source_amplitude),
        .i_cfg_we           (i_cfg.valid),
        .i_cfg_data         (i_cfg.data),
        .o_read_value       (o_res.read_value),
        .o_saturated        (o_res.saturated),
        .o_done_res         (o_res.done_res)
    );

endmodule

### rtl/core/yfdtd_chk.sv
`timescale 1ns / 1ps

module yfdtd_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_req_valid,
    input logic                              i_req_ready,
    input logic [2:0]                        i_action,
    input logic                              i_res_valid,
    input logic                              i_res_ready,
    input logic signed [yfdtd_pkg::DW-1:0]   i_read_value,
    input logic                              i_saturated,
    input logic                              i_done_res
);

    // pending result holds until taken
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped before taken");

    // undefined action answers all zero
    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_done_res |-> (i_read_value == '0) && !i_saturated)
        else $error("undefined action with nonzero result");

    // a step never answers in the next cycle
    a_step_slow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready && (i_action == yfdtd_pkg::ACT_STEP) |=> !i_res_valid)
        else $error("step answered too early");

    // no new request while a result is stuck
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |-> !i_req_ready)
        else $error("request taken while result stalled");

endmodule

bind yee_fdtd_3d_step yfdtd_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_action     (i_req.action),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_read_value (o_res.read_value),
    .i_saturated  (o_res.saturated),
    .i_done_res   (o_res.done_res)
);
